### sv/rhp_pkg.sv
// ----------------------------------------------------------------------------
// rhp_pkg
// Shared types and constants of the RTP header parser: header layout,
// status codes, register map and the result item carried through the queue.
// ----------------------------------------------------------------------------
package rhp_pkg;

    localparam int unsigned HEADER_LEN = 16;

    localparam logic [1:0] RTP_VERSION = 2'd2;
    localparam logic [7:0] PT_MASK     = 8'h7F;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SHORT   = 3'd1;
    localparam logic [2:0] ST_VERSION = 3'd2;
    localparam logic [2:0] ST_CSRC    = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;
    localparam logic [2:0] ST_LARGE   = 3'd5;

    localparam int unsigned APB_ADDR_W      = 3;
    localparam int unsigned APB_DATA_W      = 32;
    localparam logic        REG_MAX_PAYLOAD = 1'b0;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1200;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        packet_done;
        logic [2:0]  status;
        logic [6:0]  payload_type;
        logic [15:0] sequence_number;
        logic [31:0] timestamp;
        logic [31:0] source_id;
        logic [7:0]  extension_flags;
        logic [23:0] extension_seq_ack;
    } rhp_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rhp_queue_status_t;

endpackage

### sv/rhp_byte_if.sv
// ----------------------------------------------------------------------------
// rhp_byte_if
// Input channel: one packet byte per item with an end-of-packet flag.
// ----------------------------------------------------------------------------
interface rhp_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_packet;

    modport source (
        output valid,
        output data_byte,
        output end_of_packet,
        input  ready
    );

    modport sink (
        input  valid,
        input  data_byte,
        input  end_of_packet,
        output ready
    );

endinterface

### sv/rhp_result_if.sv
// ----------------------------------------------------------------------------
// rhp_result_if
// Output channel: forwarded payload bytes and per-packet header and status.
// ----------------------------------------------------------------------------
interface rhp_result_if;

    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        packet_done;
    logic [2:0]  status;
    logic [6:0]  payload_type;
    logic [15:0] sequence_number;
    logic [31:0] timestamp;
    logic [31:0] source_id;
    logic [7:0]  extension_flags;
    logic [23:0] extension_seq_ack;

    modport source (
        output valid,
        output payload_byte,
        output payload_valid,
        output packet_done,
        output status,
        output payload_type,
        output sequence_number,
        output timestamp,
        output source_id,
        output extension_flags,
        output extension_seq_ack,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload_byte,
        input  payload_valid,
        input  packet_done,
        input  status,
        input  payload_type,
        input  sequence_number,
        input  timestamp,
        input  source_id,
        input  extension_flags,
        input  extension_seq_ack,
        output ready
    );

endinterface

### sv/rhp_front.sv
// ----------------------------------------------------------------------------
// rhp_front
// Byte counter, header capture and end-of-packet classification. Builds one
// result item per payload byte or final byte and pushes it into the queue.
// ----------------------------------------------------------------------------
module rhp_front #(
    parameter int COUNT_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    rhp_byte_if.sink               in_ch,
    input  logic [15:0]            max_payload,
    input  rhp_pkg::rhp_queue_status_t q_status,
    output logic                   push,
    output rhp_pkg::rhp_item_t     item
);

    localparam int CMP_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] HDR_CNT   = COUNT_BITS'(rhp_pkg::HEADER_LEN);

    logic [COUNT_BITS-1:0] count_reg, count_next, total;
    logic [7:0]            fhb_reg, fhb_next;
    logic [6:0]            pt_reg, pt_next;
    logic [15:0]           seq_reg, seq_next;
    logic [31:0]           ts_reg, ts_next;
    logic [31:0]           ssrc_reg, ssrc_next;
    logic [7:0]            xf_reg, xf_next;
    logic [23:0]           xsa_reg, xsa_next;

    logic       accept;
    logic       is_payload;
    logic       last;
    logic [7:0] b;
    logic [2:0] st;

    assign in_ch.ready = !q_status.full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign b           = in_ch.data_byte;
    assign last        = in_ch.end_of_packet;
    assign is_payload  = (count_reg >= HDR_CNT);
    assign total       = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;
    assign push        = accept && (is_payload || last);

    always_comb
    begin
        fhb_next  = fhb_reg;
        pt_next   = pt_reg;
        seq_next  = seq_reg;
        ts_next   = ts_reg;
        ssrc_next = ssrc_reg;
        xf_next   = xf_reg;
        xsa_next  = xsa_reg;
        if (!is_payload)
        begin
            unique case (count_reg[3:0])
                4'd0:
                begin
                    fhb_next = b;
                end
                4'd1:
                begin
                    pt_next = 7'(b & rhp_pkg::PT_MASK);
                end
                4'd2, 4'd3:
                begin
                    seq_next = {seq_reg[7:0], b};
                end
                4'd4, 4'd5, 4'd6, 4'd7:
                begin
                    ts_next = {ts_reg[23:0], b};
                end
                4'd8, 4'd9, 4'd10, 4'd11:
                begin
                    ssrc_next = {ssrc_reg[23:0], b};
                end
                4'd12:
                begin
                    xf_next = b;
                end
                default:
                begin
                    xsa_next = {xsa_reg[15:0], b};
                end
            endcase
        end
    end

    always_comb
    begin
        priority if (total < HDR_CNT)
            st = rhp_pkg::ST_SHORT;
        else if (fhb_next[7:6] != rhp_pkg::RTP_VERSION)
            st = rhp_pkg::ST_VERSION;
        else if (fhb_next[3:0] != 4'd0)
            st = rhp_pkg::ST_CSRC;
        else if (total == HDR_CNT)
            st = rhp_pkg::ST_EMPTY;
        else if ((total == COUNT_MAX) ||
                 (CMP_W'(total) > CMP_W'(max_payload) + CMP_W'(rhp_pkg::HEADER_LEN)))
            st = rhp_pkg::ST_LARGE;
        else
            st = rhp_pkg::ST_OK;
    end

    always_comb
    begin
        item               = '0;
        item.payload_byte  = is_payload ? b : 8'd0;
        item.payload_valid = is_payload;
        item.packet_done   = last;
        if (last)
        begin
            item.status = st;
            if (st != rhp_pkg::ST_SHORT)
            begin
                item.payload_type      = pt_next;
                item.sequence_number   = seq_next;
                item.timestamp         = ts_next;
                item.source_id         = ssrc_next;
                item.extension_flags   = xf_next;
                item.extension_seq_ack = xsa_next;
            end
        end
    end

    assign count_next = last ? '0 : total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            fhb_reg   <= '0;
            pt_reg    <= '0;
            seq_reg   <= '0;
            ts_reg    <= '0;
            ssrc_reg  <= '0;
            xf_reg    <= '0;
            xsa_reg   <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            fhb_reg   <= last ? '0 : fhb_next;
            pt_reg    <= last ? '0 : pt_next;
            seq_reg   <= last ? '0 : seq_next;
            ts_reg    <= last ? '0 : ts_next;
            ssrc_reg  <= last ? '0 : ssrc_next;
            xf_reg    <= last ? '0 : xf_next;
            xsa_reg   <= last ? '0 : xsa_next;
        end
    end

endmodule

### sv/rhp_queue.sv
// ----------------------------------------------------------------------------
// rhp_queue
// Short register queue of result items between the front and back parts.
// ----------------------------------------------------------------------------
module rhp_queue #(
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  rhp_pkg::rhp_item_t         wr_item,
    input  logic                       pop,
    output rhp_pkg::rhp_item_t         rd_item,
    output rhp_pkg::rhp_queue_status_t q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    rhp_pkg::rhp_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign q_status.full  = (count_reg == CNT_FULL);
    assign q_status.empty = (count_reg == '0);
    assign rd_item        = entry_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

### sv/rhp_back.sv
// ----------------------------------------------------------------------------
// rhp_back
// Output register stage: takes items from the queue and presents them on the
// result channel, holding each until the receiver takes it.
// ----------------------------------------------------------------------------
module rhp_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rhp_pkg::rhp_queue_status_t q_status,
    input  rhp_pkg::rhp_item_t         rd_item,
    output logic                       pop,
    rhp_result_if.source               out_ch
);

    logic               valid_reg, valid_next;
    rhp_pkg::rhp_item_t data_reg;

    assign pop        = !q_status.empty && (!valid_reg || out_ch.ready);
    assign valid_next = pop || (valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= rd_item;
    end

    assign out_ch.valid             = valid_reg;
    assign out_ch.payload_byte      = data_reg.payload_byte;
    assign out_ch.payload_valid     = data_reg.payload_valid;
    assign out_ch.packet_done       = data_reg.packet_done;
    assign out_ch.status            = data_reg.status;
    assign out_ch.payload_type      = data_reg.payload_type;
    assign out_ch.sequence_number   = data_reg.sequence_number;
    assign out_ch.timestamp         = data_reg.timestamp;
    assign out_ch.source_id         = data_reg.source_id;
    assign out_ch.extension_flags   = data_reg.extension_flags;
    assign out_ch.extension_seq_ack = data_reg.extension_seq_ack;

endmodule

### sv/rtp_header_parser.sv
// ----------------------------------------------------------------------------
// rtp_header_parser
// RTP header parser with a fixed 16-byte extended header.
//
// in_ch carries one packet byte per item, with end_of_packet on the last
// byte. Bytes 0 to 15 are captured as header and give no result unless
// final; every later byte is forwarded as one result with payload_valid.
// The final byte gives a result with packet_done, the status and the header
// fields (zero when the packet is too short).
// Throughput is one byte per cycle while in_ch.ready is high. Each result
// passes through the item queue, written when its byte is accepted, and
// then the output register, which loads from the queue when it is free.
// When out_ch stalls, the output register and the two-entry queue fill and
// in_ch.ready stays low while the queue is full; nothing is lost.
// Reset clears the byte counter and the header capture, empties the queue and
// the output register, and sets max_payload_bytes to 1200.
// max_payload_bytes lives at APB addresses 0 to 3 (paddr[2] low); pready is always high.
// ----------------------------------------------------------------------------
module rtp_header_parser #(
    parameter int COUNT_BITS  = 16,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rhp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [rhp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rhp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    rhp_byte_if.sink                          in_ch,
    rhp_result_if.source                      out_ch
);

    logic [15:0]                max_payload_reg;
    logic                       cfg_wr;
    logic                       sel_max;
    logic                       q_push;
    logic                       q_pop;
    rhp_pkg::rhp_item_t         q_wr_item;
    rhp_pkg::rhp_item_t         q_rd_item;
    rhp_pkg::rhp_queue_status_t q_status;

    assign pready  = 1'b1;
    assign sel_max = (paddr[rhp_pkg::APB_ADDR_W-1] == rhp_pkg::REG_MAX_PAYLOAD);
    assign cfg_wr  = psel && penable && pwrite && pready && sel_max;
    assign prdata  = sel_max ? rhp_pkg::APB_DATA_W'(max_payload_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_payload_reg <= rhp_pkg::MAX_PAYLOAD_RST;
        else if (cfg_wr)
            max_payload_reg <= pwdata[15:0];
    end

    rhp_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .max_payload (max_payload_reg),
        .q_status    (q_status),
        .push        (q_push),
        .item        (q_wr_item)
    );

    rhp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_item  (q_wr_item),
        .pop      (q_pop),
        .rd_item  (q_rd_item),
        .q_status (q_status)
    );

    rhp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .rd_item  (q_rd_item),
        .pop      (q_pop),
        .out_ch   (out_ch)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_status.full))
        else $error("item pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_status.empty))
        else $error("item popped from empty queue");

    a_mid_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.packet_done) |->
            (out_ch.payload_valid && out_ch.status == rhp_pkg::ST_OK))
        else $error("non-final result without payload byte");

    a_short_no_header: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.packet_done && out_ch.status == rhp_pkg::ST_SHORT) |->
            (out_ch.source_id == 32'd0 && out_ch.timestamp == 32'd0 &&
             !out_ch.payload_valid))
        else $error("short packet reports header fields");

endmodule
